// File: hw/rtl/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

    typedef enum logic [4:0] {
        MODE_NORMAL  = 5'b00001,
        MODE_ESCAPE  = 5'b00010,
        MODE_CONT_CR = 5'b00100,
        MODE_OCT1    = 5'b01000,
        MODE_OCT2    = 5'b10000
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam int ACC_W = 6;

    // Results of one item: count of decoded bytes (0..2) and the bytes.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } dec_res_t;

endpackage

// File: hw/rtl/string_escape_decoder.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// input    in_valid / in_ready   data_byte[7:0], last_byte
// output   out_valid / out_ready decoded_byte[7:0], run_last
//
// One item per cycle while out_ready is high and each item yields at most one byte;
// an item that yields two bytes holds the output buffer until its first byte is taken.
// Path: input register, then decode into the output buffer.
// Reset clears the escape state and empties both stages.
// Output stalls back up through the buffer to in_ready.

module string_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] decoded_byte,
    output logic       run_last
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [7:0]                    s1_data_reg;
    logic                          s1_last_reg;
    esc_pkg::mode_t                mode_reg;
    esc_pkg::mode_t                mode_next;
    logic [esc_pkg::ACC_W-1:0]     acc_reg;
    logic [esc_pkg::ACC_W-1:0]     acc_next;
    esc_pkg::dec_res_t             res;
    logic                          can_load;
    logic                          adv;
    logic                          in_take;

    assign adv           = s1_valid_reg && can_load;
    assign in_ready      = !s1_valid_reg || adv;
    assign in_take       = in_valid && in_ready;
    assign s1_valid_next = in_take || (s1_valid_reg && !adv);

    esc_decode u_decode (
        .mode      (mode_reg),
        .acc       (acc_reg),
        .data_byte (s1_data_reg),
        .last_byte (s1_last_reg),
        .mode_next (mode_next),
        .acc_next  (acc_next),
        .res       (res)
    );

    esc_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (adv),
        .res          (res),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decoded_byte (decoded_byte),
        .run_last     (run_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg     <= esc_pkg::MODE_NORMAL;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (adv)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

endmodule

// File: hw/rtl/esc_decode.sv
`timescale 1ns / 1ps

module esc_decode (
    input  esc_pkg::mode_t                mode,
    input  logic [esc_pkg::ACC_W-1:0]     acc,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output esc_pkg::mode_t                mode_next,
    output logic [esc_pkg::ACC_W-1:0]     acc_next,
    output esc_pkg::dec_res_t             res
);

    function automatic esc_pkg::dec_res_t push(esc_pkg::dec_res_t r, logic [7:0] b);
        esc_pkg::dec_res_t o;
        o = r;
        if (r.count == 2'd0)
        begin
            o.byte0 = b;
            o.count = 2'd1;
        end
        else if (r.count == 2'd1)
        begin
            o.byte1 = b;
            o.count = 2'd2;
        end
        return o;
    endfunction

    logic          is_oct;
    logic [7:0]    acc_ext;

    assign is_oct  = (data_byte[7:3] == 5'b00110);
    assign acc_ext = {2'b00, acc};

    always_comb
    begin
        esc_pkg::dec_res_t          r;
        esc_pkg::mode_t             m;
        logic [esc_pkg::ACC_W-1:0]  a;
        logic                       do_plain;

        r        = '0;
        m        = esc_pkg::MODE_NORMAL;
        a        = acc;
        do_plain = 1'b0;

        unique case (mode)
            esc_pkg::MODE_ESCAPE:
            begin
                case (data_byte)
                    esc_pkg::CH_N:  r = push(r, esc_pkg::CH_LF);
                    esc_pkg::CH_R:  r = push(r, esc_pkg::CH_CR);
                    esc_pkg::CH_T:  r = push(r, esc_pkg::CH_TAB);
                    esc_pkg::CH_B:  r = push(r, esc_pkg::CH_BS);
                    esc_pkg::CH_F:  r = push(r, esc_pkg::CH_FF);
                    esc_pkg::CH_CR: m = esc_pkg::MODE_CONT_CR;
                    esc_pkg::CH_LF: m = esc_pkg::MODE_NORMAL;
                    default:
                    begin
                        if (is_oct)
                        begin
                            a = {3'b000, data_byte[2:0]};
                            m = esc_pkg::MODE_OCT1;
                        end
                        else
                        begin
                            r = push(r, data_byte);
                        end
                    end
                endcase
            end
            esc_pkg::MODE_CONT_CR:
            begin
                if (data_byte != esc_pkg::CH_LF)
                begin
                    do_plain = 1'b1;
                end
            end
            esc_pkg::MODE_OCT1:
            begin
                if (is_oct)
                begin
                    a = {acc[2:0], data_byte[2:0]};
                    m = esc_pkg::MODE_OCT2;
                end
                else
                begin
                    r        = push(r, acc_ext);
                    do_plain = 1'b1;
                end
            end
            esc_pkg::MODE_OCT2:
            begin
                if (is_oct)
                begin
                    r = push(r, {acc[4:0], data_byte[2:0]});
                end
                else
                begin
                    r        = push(r, acc_ext);
                    do_plain = 1'b1;
                end
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            if (data_byte == esc_pkg::CH_BSLASH)
            begin
                m = esc_pkg::MODE_ESCAPE;
            end
            else
            begin
                m = esc_pkg::MODE_NORMAL;
                r = push(r, data_byte);
            end
        end

        if (m != esc_pkg::MODE_OCT1 && m != esc_pkg::MODE_OCT2)
        begin
            a = '0;
        end

        // Last byte flushes a lone backslash or a held octal value.
        if (last_byte)
        begin
            if (m == esc_pkg::MODE_ESCAPE)
            begin
                r = push(r, esc_pkg::CH_BSLASH);
            end
            else if (m == esc_pkg::MODE_OCT1 || m == esc_pkg::MODE_OCT2)
            begin
                r = push(r, {2'b00, a});
            end
            m = esc_pkg::MODE_NORMAL;
            a = '0;
        end

        mode_next = m;
        acc_next  = a;
        res       = r;
    end

endmodule

// File: hw/rtl/esc_out_buf.sv
`timescale 1ns / 1ps

module esc_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  esc_pkg::dec_res_t  res,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         decoded_byte,
    output logic               run_last
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] b0_reg;
    logic [7:0] b0_next;
    logic [7:0] b1_reg;
    logic [7:0] b1_next;
    logic       pop;

    assign out_valid    = (cnt_reg != 2'd0);
    assign decoded_byte = b0_reg;
    assign run_last     = (cnt_reg == 2'd1);
    assign pop          = out_valid && out_ready;
    assign can_load     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            b0_next  = b1_reg;
        end
        if (load)
        begin
            cnt_next = res.count;
            b0_next  = res.byte0;
            b1_next  = res.byte1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT = 200000;
    localparam int DRAIN = 20;
    localparam int HOLD_AT = 80;
    localparam int HOLD_LEN = 300;
    localparam int PHASE_ITEMS = 100;

    localparam logic [7:0] DIG_0 = 8'h30;
    localparam logic [7:0] DIG_7 = 8'h37;
    localparam logic [7:0] CH_LPAREN = 8'h28;

    localparam logic [1:0] PH_FREE = 2'd0;
    localparam logic [1:0] PH_TX_GAP = 2'd1;
    localparam logic [1:0] PH_RX_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] phase;
    } raw_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } out_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] decoded_byte;
    logic       run_last;

    raw_item_t raw_items[$];
    out_byte_t want_bytes[$];

    esc_pkg::mode_t    dec_mode = esc_pkg::MODE_NORMAL;
    logic [5:0]        dec_acc = '0;
    esc_pkg::dec_res_t step_res;
    raw_item_t         nxt;
    out_byte_t         got;

    int         errors = 0;
    int         accepted = 0;
    int         cycles = 0;
    int         hold_left = 0;
    logic [1:0] cur_phase = PH_FREE;

    string_escape_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decoded_byte (decoded_byte),
        .run_last     (run_last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= DIG_0) && (c <= DIG_7);
    endfunction

    function automatic void put_byte(inout esc_pkg::dec_res_t r, input logic [7:0] b);
        if (r.count == 2'd0)
            r.byte0 = b;
        else if (r.count == 2'd1)
            r.byte1 = b;
        if (r.count < 2'd2)
            r.count = r.count + 2'd1;
    endfunction

    function automatic void take_plain(inout esc_pkg::dec_res_t r, input logic [7:0] c);
        if (c == esc_pkg::CH_BSLASH)
        begin
            dec_mode = esc_pkg::MODE_ESCAPE;
        end
        else
        begin
            dec_mode = esc_pkg::MODE_NORMAL;
            put_byte(r, c);
        end
    endfunction

    // Decoded bytes caused by one raw byte; advances the escape state.
    function automatic esc_pkg::dec_res_t decode_step(input logic [7:0] c,
                                                      input logic fin);
        esc_pkg::dec_res_t r;
        logic [8:0]        wide;
        r = '0;
        case (dec_mode)
            esc_pkg::MODE_ESCAPE:
            begin
                dec_mode = esc_pkg::MODE_NORMAL;
                case (c)
                    esc_pkg::CH_N: put_byte(r, esc_pkg::CH_LF);
                    esc_pkg::CH_R: put_byte(r, esc_pkg::CH_CR);
                    esc_pkg::CH_T: put_byte(r, esc_pkg::CH_TAB);
                    esc_pkg::CH_B: put_byte(r, esc_pkg::CH_BS);
                    esc_pkg::CH_F: put_byte(r, esc_pkg::CH_FF);
                    esc_pkg::CH_CR: dec_mode = esc_pkg::MODE_CONT_CR;
                    esc_pkg::CH_LF: ;
                    default:
                    begin
                        if (is_oct(c))
                        begin
                            dec_acc = {3'b000, c[2:0]};
                            dec_mode = esc_pkg::MODE_OCT1;
                        end
                        else
                        begin
                            put_byte(r, c);
                        end
                    end
                endcase
            end
            esc_pkg::MODE_CONT_CR:
            begin
                if (c == esc_pkg::CH_LF)
                    dec_mode = esc_pkg::MODE_NORMAL;
                else
                    take_plain(r, c);
            end
            esc_pkg::MODE_OCT1:
            begin
                if (is_oct(c))
                begin
                    dec_acc = {dec_acc[2:0], c[2:0]};
                    dec_mode = esc_pkg::MODE_OCT2;
                end
                else
                begin
                    put_byte(r, {2'b00, dec_acc});
                    take_plain(r, c);
                end
            end
            esc_pkg::MODE_OCT2:
            begin
                if (is_oct(c))
                begin
                    wide = {dec_acc, c[2:0]};
                    put_byte(r, wide[7:0]);
                    dec_mode = esc_pkg::MODE_NORMAL;
                end
                else
                begin
                    put_byte(r, {2'b00, dec_acc});
                    take_plain(r, c);
                end
            end
            default: take_plain(r, c);
        endcase
        if (dec_mode != esc_pkg::MODE_OCT1 && dec_mode != esc_pkg::MODE_OCT2)
            dec_acc = '0;
        if (fin)
        begin
            if (dec_mode == esc_pkg::MODE_ESCAPE)
                put_byte(r, esc_pkg::CH_BSLASH);
            else if (dec_mode == esc_pkg::MODE_OCT1 || dec_mode == esc_pkg::MODE_OCT2)
                put_byte(r, {2'b00, dec_acc});
            dec_mode = esc_pkg::MODE_NORMAL;
            dec_acc = '0;
        end
        return r;
    endfunction

    function automatic int gap_pct(input logic [1:0] ph, input logic rx_side);
        if (ph == PH_BOTH)
            return 9;
        if (ph == PH_TX_GAP && !rx_side)
            return 61;
        if (ph == PH_RX_STALL && rx_side)
            return 61;
        return 0;
    endfunction

    function automatic logic [7:0] esc_letter(input int idx);
        case (idx)
            0: return esc_pkg::CH_N;
            1: return esc_pkg::CH_R;
            2: return esc_pkg::CH_T;
            3: return esc_pkg::CH_B;
            default: return esc_pkg::CH_F;
        endcase
    endfunction

    function automatic logic rand_last();
        return $urandom_range(15) == 0;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic fin, input logic [1:0] ph);
        raw_item_t it;
        it.data = b;
        it.fin = fin;
        it.phase = ph;
        raw_items.push_back(it);
    endtask

    task automatic push_esc(input logic [7:0] b, input logic fin, input logic [1:0] ph);
        push_item(esc_pkg::CH_BSLASH, 1'b0, ph);
        push_item(b, fin, ph);
    endtask

    // Mostly well-formed escapes with random content, some raw noise.
    task automatic add_random_seq(input logic [1:0] ph);
        int         k;
        int         n;
        logic [7:0] b;
        k = $urandom_range(99);
        if (k < 15)
        begin
            push_item(8'($urandom_range(255)), rand_last(), ph);
        end
        else if (k < 35)
        begin
            b = 8'($urandom_range(255));
            if (b == esc_pkg::CH_BSLASH)
                b[0] = 1'b1;
            push_item(b, rand_last(), ph);
        end
        else if (k < 55)
        begin
            push_esc(esc_letter($urandom_range(4)), rand_last(), ph);
        end
        else if (k < 65)
        begin
            push_esc(8'($urandom_range(255)), rand_last(), ph);
        end
        else if (k < 85)
        begin
            push_item(esc_pkg::CH_BSLASH, rand_last(), ph);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_item(DIG_0 + 8'($urandom_range(7)), rand_last(), ph);
        end
        else
        begin
            push_item(esc_pkg::CH_BSLASH, rand_last(), ph);
            case ($urandom_range(3))
                0: push_item(esc_pkg::CH_CR, rand_last(), ph);
                1: push_item(esc_pkg::CH_LF, rand_last(), ph);
                2:
                begin
                    push_item(esc_pkg::CH_CR, rand_last(), ph);
                    push_item(esc_pkg::CH_LF, rand_last(), ph);
                end
                default:
                begin
                    push_item(esc_pkg::CH_CR, rand_last(), ph);
                    push_item(8'($urandom_range(255)), rand_last(), ph);
                end
            endcase
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                step_res = decode_step(data_byte, last_byte);
                if (step_res.count == 2'd1)
                begin
                    want_bytes.push_back({step_res.byte0, 1'b1});
                end
                else if (step_res.count == 2'd2)
                begin
                    want_bytes.push_back({step_res.byte0, 1'b0});
                    want_bytes.push_back({step_res.byte1, 1'b1});
                end
                accepted <= accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (raw_items.size() != 0 &&
                    $urandom_range(99) >= gap_pct(raw_items[0].phase, 1'b0))
                begin
                    nxt = raw_items.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.data;
                    last_byte <= nxt.fin;
                    cur_phase <= nxt.phase;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the input side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (in_valid && in_ready && accepted == HOLD_AT)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) &&
                         ($urandom_range(99) >= gap_pct(cur_phase, 1'b1));
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (want_bytes.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual byte %h last %b",
                         $time, decoded_byte, run_last);
                errors++;
            end
            else
            begin
                got = want_bytes.pop_front();
                if (decoded_byte !== got.data)
                begin
                    $display("%0t: decoded_byte mismatch: expected %h, actual %h",
                             $time, got.data, decoded_byte);
                    errors++;
                end
                if (run_last !== got.fin)
                begin
                    $display("%0t: run_last mismatch: expected %b, actual %b",
                             $time, got.fin, run_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 5; i++)
            push_esc(esc_letter(i), 1'b0, PH_FREE);
        // three digits that overflow a byte, then a plain 0xFF
        push_esc(DIG_7, 1'b0, PH_FREE);
        push_item(DIG_7, 1'b0, PH_FREE);
        push_item(DIG_7, 1'b0, PH_FREE);
        push_item(8'hFF, 1'b0, PH_FREE);
        // two digits ended by a non-octal zero byte
        push_esc(DIG_0 + 8'd1, 1'b0, PH_FREE);
        push_item(DIG_0 + 8'd2, 1'b0, PH_FREE);
        push_item(8'h00, 1'b0, PH_FREE);
        push_esc(esc_pkg::CH_CR, 1'b0, PH_FREE);
        push_item(esc_pkg::CH_LF, 1'b0, PH_FREE);
        // CR continuation without LF, then an escaped paren
        push_esc(esc_pkg::CH_CR, 1'b0, PH_FREE);
        push_esc(CH_LPAREN, 1'b0, PH_FREE);
        push_item(esc_pkg::CH_BSLASH, 1'b1, PH_FREE);
        push_esc(DIG_0 + 8'd5, 1'b1, PH_FREE);
        push_esc(esc_pkg::CH_CR, 1'b1, PH_FREE);

        for (int ph = 0; ph < 4; ph++)
        begin
            int target;
            target = raw_items.size() + PHASE_ITEMS;
            while (raw_items.size() < target)
                add_random_seq(2'(ph));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (raw_items.size() != 0 || in_valid || want_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
